FILE: sv/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, register indexes and constants for pressure compensation.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int DW = 32;   // datapath width, every intermediate wraps here
  localparam int UPW = 19;  // raw pressure after the oversampling shift

  localparam logic [2:0] REG_AC1_AC2 = 3'd0;
  localparam logic [2:0] REG_AC3_AC4 = 3'd1;
  localparam logic [2:0] REG_AC5_AC6 = 3'd2;
  localparam logic [2:0] REG_B1_B2   = 3'd3;
  localparam logic [2:0] REG_MC_MD   = 3'd4;
  localparam logic [2:0] REG_OSS     = 3'd5;

  localparam logic signed [31:0] B5_OFFSET  = 32'sd4000;
  localparam logic [31:0]        P_SCALE    = 32'd50000;
  localparam logic signed [31:0] P_COEF_A   = 32'sd3038;
  localparam logic signed [31:0] P_COEF_B   = -32'sd7357;
  localparam logic signed [31:0] P_COEF_C   = 32'sd3791;
  localparam logic signed [31:0] AC4_OFFSET = 32'sd32768;
  localparam int                 MC_SHIFT   = 11;
  localparam logic [19:0]        P_MAX      = 20'hFFFFF;

endpackage

FILE: sv/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module bpc_div
  import bpc_pkg::*;
#(
  parameter int W  = DW,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [W-1:0]  quot,
  output logic [SW-1:0] side_out
);

  logic [W-1:0]  rem_w  [W+1];
  logic [W-1:0]  nq_w   [W+1];
  logic [W-1:0]  den_w  [W+1];
  logic [SW-1:0] side_w [W+1];
  logic          v_w    [W+1];

  assign rem_w[0]  = '0;
  assign nq_w[0]   = num;
  assign den_w[0]  = den;
  assign side_w[0] = side_in;
  assign v_w[0]    = in_valid;

  for (genvar k = 0; k < W; k++) begin : g_st
    logic [W:0]    trial;
    logic          ge;
    logic [W-1:0]  rem_r, nq_r, den_r;
    logic [SW-1:0] side_r;
    logic          v_r;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_w[k], nq_w[k][W-1]};
    assign ge    = (trial >= {1'b0, den_w[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= ge ? W'(trial - {1'b0, den_w[k]}) : trial[W-1:0];
        nq_r   <= {nq_w[k][W-2:0], ge};
        den_r  <= den_w[k];
        side_r <= side_w[k];
      end
    end

    assign rem_w[k+1]  = rem_r;
    assign nq_w[k+1]   = nq_r;
    assign den_w[k+1]  = den_r;
    assign side_w[k+1] = side_r;
    assign v_w[k+1]    = v_r;
  end

  assign out_valid = v_w[W];
  assign quot      = nq_w[W];
  assign side_out  = side_w[W];

endmodule

FILE: sv/barometric_pressure_compensation.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Integer temperature and pressure compensation for a barometric sensor.
// ----------------------------------------------------------------------------
// Write the five calibration words and the oversampling setting through the
// cfg_ port while no word is in flight. Each input word carries one raw
// temperature and one raw 24-bit pressure reading; each output word carries
// temperature in 0.1 degC, pressure in Pa and a divide error flag (fields
// forced to zero when a divisor is zero).
// The pipeline has 13 arithmetic stages plus two 32-stage dividers (one
// quotient bit per stage) for X2 and the final pressure quotient.
// Throughput is one word per cycle unless the output stalls; the dividers
// are fully pipelined. The whole pipeline advances together: when the
// output register holds a word the receiver does not take, every stage
// holds and in_ready drops, so nothing is lost or repeated. Reset clears
// all valid bits and the calibration registers to zero.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation
  import bpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_raw_temperature,
  input  logic [23:0]        in_raw_pressure,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_temperature_tenths,
  output logic [19:0]        out_pressure_pa,
  output logic               out_divide_error
);

  logic [31:0] c_ac12_r, c_ac34_r, c_ac56_r, c_b12_r, c_mcmd_r;
  logic [1:0]  oss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_ac12_r <= '0;
      c_ac34_r <= '0;
      c_ac56_r <= '0;
      c_b12_r  <= '0;
      c_mcmd_r <= '0;
      oss_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AC1_AC2: c_ac12_r <= cfg_data;
        REG_AC3_AC4: c_ac34_r <= cfg_data;
        REG_AC5_AC6: c_ac56_r <= cfg_data;
        REG_B1_B2:   c_b12_r  <= cfg_data;
        REG_MC_MD:   c_mcmd_r <= cfg_data;
        REG_OSS:     oss_r    <= cfg_data[1:0];
        default:     ;
      endcase
    end
  end

  logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [31:0]        ac4, ac5, ac6;
  assign ac1 = 32'($signed(c_ac12_r[31:16]));
  assign ac2 = 32'($signed(c_ac12_r[15:0]));
  assign ac3 = 32'($signed(c_ac34_r[31:16]));
  assign ac4 = {16'd0, c_ac34_r[15:0]};
  assign ac5 = {16'd0, c_ac56_r[31:16]};
  assign ac6 = {16'd0, c_ac56_r[15:0]};
  assign b1  = 32'($signed(c_b12_r[31:16]));
  assign b2  = 32'($signed(c_b12_r[15:0]));
  assign mc  = 32'($signed(c_mcmd_r[31:16]));
  assign md  = 32'($signed(c_mcmd_r[15:0]));

  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage 1: capture, apply the oversampling shift
  logic        v1_r;
  logic [15:0] ut1_r;
  logic [UPW-1:0] up1_r;
  logic [23:0] up_sh;
  assign up_sh = in_raw_pressure >> (4'd8 - {2'b00, oss_r});

  // stage 2: X1
  logic        v2_r;
  logic signed [31:0] x1_2_r;
  logic [UPW-1:0] up2_r;
  logic [31:0] m_ut;
  assign m_ut = (32'(ut1_r) - ac6) * ac5;

  // stage 3: divider operands for X2
  logic        v3_r;
  logic signed [31:0] div3, num3;
  logic [31:0] dabs3_r, nabs3_r;
  logic        neg3_r, err3_r;
  logic signed [31:0] x1_3_r;
  logic [UPW-1:0] up3_r;
  assign div3 = x1_2_r + md;
  assign num3 = mc <<< MC_SHIFT;

  localparam int S1W = DW + UPW + 2;
  logic           d1_v;
  logic [DW-1:0]  d1_q;
  logic [S1W-1:0] d1_side;

  bpc_div #(.W(DW), .SW(S1W)) u_div_x2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v3_r),
    .num      (nabs3_r),
    .den      (dabs3_r),
    .side_in  ({x1_3_r, up3_r, neg3_r, err3_r}),
    .out_valid(d1_v),
    .quot     (d1_q),
    .side_out (d1_side)
  );

  // stage 4: B5, temperature, B6
  logic signed [31:0] d1_x1, x2_4, b5_4, t_4;
  logic [UPW-1:0] d1_up;
  logic        d1_neg, d1_err;
  assign {d1_x1, d1_up, d1_neg, d1_err} = d1_side;
  assign x2_4 = d1_neg ? -$signed(d1_q) : $signed(d1_q);
  assign b5_4 = d1_x1 + x2_4;
  assign t_4  = (b5_4 + 32'sd8) >>> 4;

  logic        v4_r, err4_r;
  logic signed [15:0] t4_r;
  logic signed [31:0] b6_4_r;
  logic [UPW-1:0] up4_r;

  // stage 5: the square and first products of B6
  logic        v5_r, err5_r;
  logic signed [15:0] t5_r;
  logic [UPW-1:0] up5_r;
  logic signed [31:0] sq5_r, a2b6_5_r, a3b6_5_r;
  logic [31:0] m_sq, m_a2, m_a3;
  assign m_sq = b6_4_r * b6_4_r;
  assign m_a2 = ac2 * b6_4_r;
  assign m_a3 = ac3 * b6_4_r;

  // stage 6: X3 for B3, X1 and X2 for B4
  logic        v6_r, err6_r;
  logic signed [15:0] t6_r;
  logic [UPW-1:0] up6_r;
  logic signed [31:0] x3_6_r, x1c6_r, x2c6_r;
  logic [31:0] m_b2, m_b1;
  assign m_b2 = b2 * sq5_r;
  assign m_b1 = b1 * sq5_r;

  // stage 7: B3 and X3 for B4
  logic        v7_r, err7_r;
  logic signed [15:0] t7_r;
  logic [UPW-1:0] up7_r;
  logic signed [31:0] b3_7_r, x3b7_r, b3v;
  assign b3v = (((ac1 <<< 2) + x3_6_r) <<< oss_r) + 32'sd2;

  // stage 8: B4 and B7
  logic        v8_r, err8_r;
  logic signed [15:0] t8_r;
  logic [31:0] b4_8_r, b7_8_r, m_b4, m_b7;
  assign m_b4 = ac4 * 32'(x3b7_r + AC4_OFFSET);
  assign m_b7 = (32'(up7_r) - 32'(b3_7_r)) * (P_SCALE >> oss_r);

  // stage 9: divider operands for p
  logic        v9_r;
  logic [31:0] num9_r, den9_r;
  logic        dbl9_r, err9_r;
  logic signed [15:0] t9_r;

  localparam int S2W = 16 + 2;
  logic           d2_v;
  logic [DW-1:0]  d2_q;
  logic [S2W-1:0] d2_side;

  bpc_div #(.W(DW), .SW(S2W)) u_div_p (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v9_r),
    .num      (num9_r),
    .den      (den9_r),
    .side_in  ({t9_r, dbl9_r, err9_r}),
    .out_valid(d2_v),
    .quot     (d2_q),
    .side_out (d2_side)
  );

  logic signed [15:0] d2_t;
  logic        d2_dbl, d2_err;
  assign {d2_t, d2_dbl, d2_err} = d2_side;

  // stage 10: p
  logic        v10_r, err10_r;
  logic signed [15:0] t10_r;
  logic signed [31:0] p10_r;

  // stage 11: (p>>8)^2 and the linear term
  logic        v11_r, err11_r;
  logic signed [15:0] t11_r;
  logic signed [31:0] p11_r, sq11_r, x2_11_r, pp10;
  logic [31:0] m_lin;
  assign pp10  = p10_r >>> 8;
  assign m_lin = P_COEF_B * p10_r;

  // stage 12: quadratic term
  logic        v12_r, err12_r;
  logic signed [15:0] t12_r;
  logic signed [31:0] p12_r, x1_12_r, x2_12_r;
  logic [31:0] m_quad;
  assign m_quad = sq11_r * P_COEF_A;

  // stage 13: final sum and saturation
  logic signed [31:0] pf;
  assign pf = p12_r + ((x1_12_r + x2_12_r + P_COEF_C) >>> 4);

  logic signed [15:0] out_t_r;
  logic [19:0] out_p_r;
  logic        out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;  v2_r <= 1'b0;  v3_r <= 1'b0;  v4_r <= 1'b0;
      v5_r <= 1'b0;  v6_r <= 1'b0;  v7_r <= 1'b0;  v8_r <= 1'b0;
      v9_r <= 1'b0;  v10_r <= 1'b0; v11_r <= 1'b0; v12_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= d1_v;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
      v9_r <= v8_r;
      v10_r <= d2_v;
      v11_r <= v10_r;
      v12_r <= v11_r;
      out_valid_r <= v12_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ut1_r <= in_raw_temperature;
      up1_r <= up_sh[UPW-1:0];

      x1_2_r <= $signed(m_ut) >>> 15;
      up2_r  <= up1_r;

      dabs3_r <= div3[31] ? 32'(-div3) : div3;
      nabs3_r <= num3[31] ? 32'(-num3) : num3;
      neg3_r  <= num3[31] ^ div3[31];
      err3_r  <= (div3 == 32'sd0);
      x1_3_r  <= x1_2_r;
      up3_r   <= up2_r;

      err4_r <= d1_err;
      up4_r  <= d1_up;
      b6_4_r <= b5_4 - B5_OFFSET;
      if (t_4 > 32'sd32767) begin
        t4_r <= 16'sh7FFF;
      end else if (t_4 < -32'sd32768) begin
        t4_r <= -16'sh8000;
      end else begin
        t4_r <= t_4[15:0];
      end

      err5_r   <= err4_r;
      t5_r     <= t4_r;
      up5_r    <= up4_r;
      sq5_r    <= $signed(m_sq) >>> 12;
      a2b6_5_r <= m_a2;
      a3b6_5_r <= m_a3;

      err6_r <= err5_r;
      t6_r   <= t5_r;
      up6_r  <= up5_r;
      x3_6_r <= ($signed(m_b2) >>> 11) + (a2b6_5_r >>> 11);
      x1c6_r <= a3b6_5_r >>> 13;
      x2c6_r <= $signed(m_b1) >>> 16;

      err7_r <= err6_r;
      t7_r   <= t6_r;
      up7_r  <= up6_r;
      // divide by four, truncating toward zero
      b3_7_r <= (b3v + (b3v[31] ? 32'sd3 : 32'sd0)) >>> 2;
      x3b7_r <= (x1c6_r + x2c6_r + 32'sd2) >>> 2;

      err8_r <= err7_r;
      t8_r   <= t7_r;
      b4_8_r <= m_b4 >> 15;
      b7_8_r <= m_b7;

      // double before the divide unless B7 would overflow, then after
      dbl9_r <= b7_8_r[31];
      num9_r <= b7_8_r[31] ? b7_8_r : {b7_8_r[30:0], 1'b0};
      den9_r <= b4_8_r;
      err9_r <= err8_r || (b4_8_r == 32'd0);
      t9_r   <= t8_r;

      err10_r <= d2_err;
      t10_r   <= d2_t;
      p10_r   <= d2_dbl ? {d2_q[30:0], 1'b0} : d2_q;

      err11_r <= err10_r;
      t11_r   <= t10_r;
      p11_r   <= p10_r;
      sq11_r  <= pp10 * pp10;
      x2_11_r <= $signed(m_lin) >>> 16;

      err12_r <= err11_r;
      t12_r   <= t11_r;
      p12_r   <= p11_r;
      x2_12_r <= x2_11_r;
      x1_12_r <= $signed(m_quad) >>> 16;

      out_err_r <= err12_r;
      if (err12_r) begin
        out_t_r <= '0;
        out_p_r <= '0;
      end else begin
        out_t_r <= t12_r;
        if (pf < 32'sd0) begin
          out_p_r <= '0;
        end else if (pf > $signed({12'd0, P_MAX})) begin
          out_p_r <= P_MAX;
        end else begin
          out_p_r <= pf[19:0];
        end
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_temperature_tenths = out_t_r;
  assign out_pressure_pa        = out_p_r;
  assign out_divide_error       = out_err_r;

endmodule

FILE: sv/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks for the pressure compensation block.
// ----------------------------------------------------------------------------
module bpc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_temperature_tenths,
  input logic [19:0]        out_pressure_pa,
  input logic               out_divide_error
);

  // a held word stays valid and keeps its pressure
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pressure_pa))
    else $error("output word changed while stalled");

  // stalled output stalls the input side
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // divide error zeroes both results
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_error |->
      out_temperature_tenths == 16'sd0 && out_pressure_pa == 20'd0)
    else $error("results not cleared on divide error");

  // reset clears the output valid
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_ready               (in_ready),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_temperature_tenths (out_temperature_tenths),
  .out_pressure_pa        (out_pressure_pa),
  .out_divide_error       (out_divide_error)
);

FILE: bench/tb_barometric_pressure_compensation.sv
// ----------------------------------------------------------------------------
// tb_barometric_pressure_compensation
// Self-checking bench for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
// A local integer model computes each expected word, which is queued when
// the input word is accepted and compared field by field with each output
// word. Calibration sets go from zero through datasheet values to all-ones
// and random values; both sides stall at random, at rates set per phase.
// ----------------------------------------------------------------------------
module tb_barometric_pressure_compensation
  import bpc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [19:0]        press;
    logic               derr;
  } comp_word_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [15:0]        in_raw_temperature;
  logic [23:0]        in_raw_pressure;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_temperature_tenths;
  logic [19:0]        out_pressure_pa;
  logic               out_divide_error;

  barometric_pressure_compensation u_dut (.*);

  logic [31:0] cal_word [0:4];
  logic [1:0]  oss_sel;
  comp_word_t  pending_q[$];
  int          n_err;
  int          n_sent;
  int          n_checked;
  int          send_idle_pct;
  int          recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("barometric_pressure_compensation verification failed");
    $finish;
  end

  function automatic longint wrap32(longint v);
    return longint'(signed'(v[31:0]));
  endfunction

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic comp_word_t compensate(logic [15:0] ut_raw, logic [23:0] up_raw);
    comp_word_t r;
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint x1, x2, x3, b3, b5, b6, dv, t, p, sq;
    logic [31:0] b4, b7, up, tmp;
    ac1 = longint'(signed'(cal_word[0][31:16]));
    ac2 = longint'(signed'(cal_word[0][15:0]));
    ac3 = longint'(signed'(cal_word[1][31:16]));
    ac4 = longint'(cal_word[1][15:0]);
    ac5 = longint'(cal_word[2][31:16]);
    ac6 = longint'(cal_word[2][15:0]);
    b1  = longint'(signed'(cal_word[3][31:16]));
    b2  = longint'(signed'(cal_word[3][15:0]));
    mc  = longint'(signed'(cal_word[4][31:16]));
    md  = longint'(signed'(cal_word[4][15:0]));
    up  = 32'(up_raw) >> (8 - oss_sel);
    r = '0;
    x1 = sra(wrap32((longint'(ut_raw) - ac6) * ac5), 15);
    dv = wrap32(x1 + md);
    if (dv == 0) begin
      r.derr = 1'b1;
      return r;
    end
    x2 = wrap32((mc * 2048) / dv);
    b5 = wrap32(x1 + x2);
    t  = sra(wrap32(b5 + 8), 4);
    b6 = wrap32(b5 - 4000);
    sq = sra(wrap32(b6 * b6), 12);
    x1 = sra(wrap32(b2 * sq), 11);
    x2 = sra(wrap32(ac2 * b6), 11);
    x3 = wrap32(x1 + x2);
    b3 = wrap32(wrap32(wrap32(wrap32(ac1 * 4) + x3) * (longint'(1) << oss_sel)) + 2) / 4;
    x1 = sra(wrap32(ac3 * b6), 13);
    x2 = sra(wrap32(b1 * sq), 16);
    x3 = sra(wrap32(wrap32(x1 + x2) + 2), 2);
    tmp = 32'(wrap32(x3 + 32768));
    b4 = 32'(longint'(ac4) * longint'(tmp)) >> 15;
    if (b4 == 0) begin
      r.derr = 1'b1;
      return r;
    end
    b7 = 32'(longint'(up - 32'(b3)) * longint'(32'd50000 >> oss_sel));
    if (b7 < 32'h8000_0000) p = wrap32(longint'((b7 * 32'd2) / b4));
    else p = wrap32(longint'(b7 / b4) * 2);
    x1 = wrap32(sra(p, 8) * sra(p, 8));
    x1 = sra(wrap32(x1 * 3038), 16);
    x2 = sra(wrap32(-7357 * p), 16);
    p  = wrap32(p + sra(wrap32(wrap32(x1 + x2) + 3791), 4));
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    if (p > 1048575) p = 1048575;
    if (p < 0) p = 0;
    r.temp  = t[15:0];
    r.press = p[19:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    n_err++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Output side: random stall and compare against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        comp_word_t e;
        if (pending_q.size() == 0) begin
          report_mismatch("output word with nothing expected");
        end else begin
          e = pending_q.pop_front();
          n_checked++;
          if (out_temperature_tenths !== e.temp)
            report_mismatch($sformatf("temperature %0d exp %0d",
                                      out_temperature_tenths, e.temp));
          if (out_pressure_pa !== e.press)
            report_mismatch($sformatf("pressure %0d exp %0d", out_pressure_pa, e.press));
          if (out_divide_error !== e.derr)
            report_mismatch($sformatf("divide_error %0b exp %0b",
                                      out_divide_error, e.derr));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Leave in_valid high after the word; drop it only when idling.
  task automatic send_word(logic [15:0] ut, logic [23:0] up);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_raw_temperature <= ut;
    in_raw_pressure    <= up;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_q.push_back(compensate(ut, up));
    n_sent++;
  endtask

  task automatic drain;
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (pending_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < 3'd5) cal_word[idx] = val;
    else if (idx == REG_OSS) oss_sel = val[1:0];
  endtask

  task automatic load_cal(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                          logic [31:0] c3, logic [31:0] c4, logic [1:0] oss);
    drain();
    write_reg(REG_AC1_AC2, c0);
    write_reg(REG_AC3_AC4, c1);
    write_reg(REG_AC5_AC6, c2);
    write_reg(REG_B1_B2, c3);
    write_reg(REG_MC_MD, c4);
    write_reg(REG_OSS, {30'd0, oss});
  endtask

  // Datasheet-like calibration with a random oversampling setting.
  task automatic load_typical_cal;
    load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
             {16'd32757, 16'd23153}, {16'd6190, 16'd4},
             {-16'sd8711, 16'd2868}, 2'($urandom_range(3)));
  endtask

  task automatic test_directed;
    // zero calibration: X1+MD is zero, every word raises the divide error
    send_word(16'h0000, 24'h000000);
    send_word(16'hFFFF, 24'hFFFFFF);
    // unknown register indexes are ignored
    drain();
    write_reg(3'd6, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'hFFFF_FFFF);
    for (int o = 0; o < 4; o++) begin
      load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
               {16'd32757, 16'd23153}, {16'd6190, 16'd4},
               {-16'sd8711, 16'd2868}, 2'(o));
      send_word(16'd27898, 24'h5D23 << (8 - o));
      send_word(16'h0000, 24'h000000);
      send_word(16'hFFFF, 24'hFFFFFF);
      send_word(16'h8000, 24'h800000);
    end
    // AC4 zero forces B4 to zero
    load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd0},
             {16'd32757, 16'd23153}, {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'd0);
    send_word(16'd27898, 24'h5D2300);
    // MC at its minimum, MD -1: quotient extremes and wraps
    load_cal(32'h8000_7FFF, 32'h8000_FFFF, 32'hFFFF_0000, 32'h8000_8000,
             32'h8000_FFFF, 2'd3);
    send_word(16'h0000, 24'hFFFFFF);
    send_word(16'h5555, 24'hAAAAAA);
    load_cal(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 2'd3);
    send_word(16'hAAAA, 24'h555555);
    send_word(16'hFFFF, 24'h000000);
  endtask

  task automatic test_random(int count);
    for (int k = 0; k < count; k++) begin
      if (k % 100 == 0) begin
        if ($urandom_range(3) == 0)
          load_cal($urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom_range(3)));
        else
          load_typical_cal();
      end
      if ($urandom_range(4) == 0)
        send_word(16'($urandom), 24'($urandom));
      else
        send_word(16'($urandom_range(32000, 20000)), 24'($urandom_range(24'hFFFFFF, 24'h400000)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_raw_temperature = '0;
    in_raw_pressure = '0;
    out_ready = 1'b0;
    n_err = 0;
    n_sent = 0;
    n_checked = 0;
    oss_sel = '0;
    for (int i = 0; i < 5; i++) cal_word[i] = '0;
    send_idle_pct = 7;
    recv_idle_pct = 79;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(330);
    send_idle_pct = 79;
    recv_idle_pct = 7;
    test_random(330);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(340);
    drain();
    if (pending_q.size() != 0) report_mismatch("expected words never arrived");
    $display("Sent %0d words over zero, typical, random and all-ones calibration,",
             n_sent);
    $display("all four oversampling settings; %0d output words checked.", n_checked);
    if (n_err == 0) begin
      $display("barometric_pressure_compensation verification clean");
    end else begin
      $display("barometric_pressure_compensation verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/bpc_pkg.sv
sv/bpc_div.sv
sv/barometric_pressure_compensation.sv
sv/bpc_checker.sv
bench/tb_barometric_pressure_compensation.sv
